FILE: hdl/yld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yld_pkg: shared definitions for the line deinterlacer
// Window geometry, row-width limits, register indexes and the temporal
// sample bundle that travels with each column.
// ----------------------------------------------------------------------------
package yld_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int MIN_WIDTH = 7;
    localparam int WIN       = 7;
    localparam int CEN       = 3;
    localparam int FIRST_OUT = 2 * CEN;
    localparam int TDEPTH    = 3;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SPATIAL_CHECK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH     = 2'd1;

    localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 13'd720;

    typedef logic [7:0] pix_t;

    typedef struct packed {
        pix_t prev_mid;
        pix_t next_mid;
        pix_t prev_up2;
        pix_t prev_down2;
        pix_t next_up2;
        pix_t next_down2;
        pix_t pf_above;
        pix_t pf_below;
        pix_t nf_above;
        pix_t nf_below;
    } tfields_t;

    function automatic pix_t abs_diff(input pix_t a, input pix_t b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage
`default_nettype wire

FILE: hdl/yadif_line_deinterlace.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yadif_line_deinterlace: edge-directed reconstruction of a missing line
// Seven-column spatial window, temporal clamp with optional spatial check.
// ----------------------------------------------------------------------------
// One column beat in, at most one pixel out, one beat per clock sustained
// while out_ready is high. A beat's window shift happens at acceptance;
// the direction search and temporal clamp run combinationally between the
// window registers and the output register, which loads the result once
// free (the pixel for input column n belongs to column n-3). Only input
// columns 6 through row_width-1 yield a pixel; the first six beats of each
// row fill the window and produce nothing. in_ready drops only while a
// computed pixel waits in the output register and another is pending behind
// it. row_width is clamped to 7..4096; cfg_ready is always high.
// ----------------------------------------------------------------------------
module yadif_line_deinterlace
    import yld_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ROW_W-1:0]     cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           above_pixel,
    input  wire logic [7:0]           below_pixel,
    input  wire logic [7:0]           temporal_prev_mid,
    input  wire logic [7:0]           temporal_next_mid,
    input  wire logic [7:0]           temporal_prev_up2,
    input  wire logic [7:0]           temporal_prev_down2,
    input  wire logic [7:0]           temporal_next_up2,
    input  wire logic [7:0]           temporal_next_down2,
    input  wire logic [7:0]           prev_frame_above,
    input  wire logic [7:0]           prev_frame_below,
    input  wire logic [7:0]           next_frame_above,
    input  wire logic [7:0]           next_frame_below,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                pixel_out
);

    logic                spatial_en_reg;
    logic [ROW_W-1:0]    row_width_reg;
    logic [COL_W-1:0]    count_reg;
    logic [COL_W-1:0]    count_next;
    logic                pend_reg;
    logic                pend_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    pix_t                pixel_out_reg;

    pix_t                above_win_reg [WIN];
    pix_t                below_win_reg [WIN];
    tfields_t            tdelay_reg [TDEPTH];
    tfields_t            aligned_reg;
    tfields_t            cur_fields;

    logic                out_free;
    logic                in_acc;
    logic                calc_load;
    logic [ROW_W-1:0]    rw_m1;
    logic [COL_W-1:0]    last_col;
    pix_t                pixel_calc;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = !pend_reg || out_free;
    assign in_acc    = in_valid && in_ready;
    assign calc_load = pend_reg && out_free;
    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;

    assign cur_fields = '{prev_mid:   temporal_prev_mid,
                          next_mid:   temporal_next_mid,
                          prev_up2:   temporal_prev_up2,
                          prev_down2: temporal_prev_down2,
                          next_up2:   temporal_next_up2,
                          next_down2: temporal_next_down2,
                          pf_above:   prev_frame_above,
                          pf_below:   prev_frame_below,
                          nf_above:   next_frame_above,
                          nf_below:   next_frame_below};

    // effective last column of the row, after width clamping
    assign rw_m1 = row_width_reg - 1'b1;
    always_comb
    begin
        if (row_width_reg < ROW_W'(MIN_WIDTH))
        begin
            last_col = COL_W'(MIN_WIDTH - 1);
        end
        else if (row_width_reg > ROW_W'(MAX_WIDTH))
        begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = COL_W'(rw_m1);
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        if (calc_load)
        begin
            out_valid_next = 1'b1;
            pend_next      = 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_acc)
        begin
            pend_next  = (count_reg >= COL_W'(FIRST_OUT));
            count_next = (count_reg >= last_col) ? '0 : count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spatial_en_reg <= 1'b1;
            row_width_reg  <= ROW_WIDTH_RESET;
            count_reg      <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_SPATIAL_CHECK: spatial_en_reg <= cfg_data[0];
                    CFG_ROW_WIDTH:     row_width_reg  <= cfg_data;
                    default:           ;
                endcase
            end
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // window, temporal delay line and result data carry no reset
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int i = 0; i < WIN - 1; i++)
            begin
                above_win_reg[i] <= above_win_reg[i+1];
                below_win_reg[i] <= below_win_reg[i+1];
            end
            above_win_reg[WIN-1] <= above_pixel;
            below_win_reg[WIN-1] <= below_pixel;
            aligned_reg <= tdelay_reg[0];
            for (int i = 0; i < TDEPTH - 1; i++)
            begin
                tdelay_reg[i] <= tdelay_reg[i+1];
            end
            tdelay_reg[TDEPTH-1] <= cur_fields;
        end
        if (calc_load)
        begin
            pixel_out_reg <= pixel_calc;
        end
    end

    // direction search and temporal clamp for the center column
    logic [9:0]         score [5];
    pix_t               pred  [5];
    logic [9:0]         best;
    pix_t               spred;
    pix_t               c_pix;
    pix_t               e_pix;
    logic [8:0]         sum_d;
    logic [8:0]         sum_b;
    logic [8:0]         sum_f;
    logic [8:0]         sum_t1;
    logic [8:0]         sum_t2;
    logic signed [10:0] d_s;
    logic signed [10:0] b_s;
    logic signed [10:0] f_s;
    logic signed [10:0] c_s;
    logic signed [10:0] e_s;
    logic signed [10:0] td0;
    logic signed [10:0] td1;
    logic signed [10:0] td2;
    logic signed [10:0] diff;
    logic signed [10:0] hi;
    logic signed [10:0] lo;
    logic signed [10:0] pmax;
    logic signed [10:0] pmin;
    logic signed [10:0] pr_s;
    logic signed [10:0] res_s;

    always_comb
    begin
        for (int jj = 0; jj < 5; jj++)
        begin
            score[jj] = 10'(abs_diff(above_win_reg[CEN - 1 + jj - 2],
                                     below_win_reg[CEN - 1 - jj + 2]))
                      + 10'(abs_diff(above_win_reg[CEN + jj - 2],
                                     below_win_reg[CEN - jj + 2]))
                      + 10'(abs_diff(above_win_reg[CEN + 1 + jj - 2],
                                     below_win_reg[CEN + 1 - jj + 2]));
            pred[jj] = pix_t'((9'(above_win_reg[CEN + jj - 2])
                             + 9'(below_win_reg[CEN - jj + 2])) >> 1);
        end

        // center first, then left-leaning, then right-leaning directions
        best  = score[2];
        spred = pred[2];
        if (best > score[1])
        begin
            best  = score[1];
            spred = pred[1];
            if (best > score[0])
            begin
                best  = score[0];
                spred = pred[0];
            end
        end
        if (best > score[3])
        begin
            best  = score[3];
            spred = pred[3];
            if (best > score[4])
            begin
                best  = score[4];
                spred = pred[4];
            end
        end

        c_pix  = above_win_reg[CEN];
        e_pix  = below_win_reg[CEN];
        sum_d  = 9'(aligned_reg.prev_mid) + 9'(aligned_reg.next_mid);
        sum_b  = 9'(aligned_reg.prev_up2) + 9'(aligned_reg.next_up2);
        sum_f  = 9'(aligned_reg.prev_down2) + 9'(aligned_reg.next_down2);
        sum_t1 = 9'(abs_diff(aligned_reg.pf_above, c_pix))
               + 9'(abs_diff(aligned_reg.pf_below, e_pix));
        sum_t2 = 9'(abs_diff(aligned_reg.nf_above, c_pix))
               + 9'(abs_diff(aligned_reg.nf_below, e_pix));

        d_s = $signed({3'b000, sum_d[8:1]});
        b_s = $signed({3'b000, sum_b[8:1]});
        f_s = $signed({3'b000, sum_f[8:1]});
        c_s = $signed({3'b000, c_pix});
        e_s = $signed({3'b000, e_pix});
        td0 = $signed({3'b000, abs_diff(aligned_reg.prev_mid, aligned_reg.next_mid) >> 1});
        td1 = $signed({3'b000, sum_t1[8:1]});
        td2 = $signed({3'b000, sum_t2[8:1]});

        diff = (td0 > td1) ? td0 : td1;
        diff = (diff > td2) ? diff : td2;

        hi = ((d_s - e_s) > (d_s - c_s)) ? (d_s - e_s) : (d_s - c_s);
        pmin = ((b_s - c_s) < (f_s - e_s)) ? (b_s - c_s) : (f_s - e_s);
        hi = (hi > pmin) ? hi : pmin;
        lo = ((d_s - e_s) < (d_s - c_s)) ? (d_s - e_s) : (d_s - c_s);
        pmax = ((b_s - c_s) > (f_s - e_s)) ? (b_s - c_s) : (f_s - e_s);
        lo = (lo < pmax) ? lo : pmax;

        if (spatial_en_reg)
        begin
            diff = (diff > lo) ? diff : lo;
            diff = (diff > -hi) ? diff : -hi;
        end

        pr_s = $signed({3'b000, spred});
        if (pr_s > d_s + diff)
        begin
            res_s = d_s + diff;
        end
        else if (pr_s < d_s - diff)
        begin
            res_s = d_s - diff;
        end
        else
        begin
            res_s = pr_s;
        end
        pixel_calc = res_s[7:0];
    end

endmodule
`default_nettype wire

FILE: dv/tb_yadif_line_deinterlace.sv
// ----------------------------------------------------------------------------
// tb_yadif_line_deinterlace: self-checking bench for the line deinterlacer
// Drives column beats and register writes over valid/ready, mirrors the
// seven-column window and temporal clamp in a scoreboard, and compares every
// output pixel in order. The bench varies the row widths, the spatial check
// setting and the idle and stall patterns of the sender and the receiver.
// ----------------------------------------------------------------------------
module tb_yadif_line_deinterlace;
    import yld_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 90;
    localparam int STUCK_LIMIT  = 3000;
    localparam int NUM_PHASES   = 8;

    // indexes past the register list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    typedef struct packed {
        pix_t     above;
        pix_t     below;
        tfields_t t;
    } column_t;

    class deinterlace_scoreboard;
        pix_t        above_win [WIN];
        pix_t        below_win [WIN];
        tfields_t    tdelay [TDEPTH];
        int unsigned col;
        bit          spatial_on;
        logic [ROW_W-1:0] row_w;
        pix_t        expected_pixels [$];
        int          errors;

        function new();
            for (int i = 0; i < WIN; i++)
            begin
                above_win[i] = '0;
                below_win[i] = '0;
            end
            for (int i = 0; i < TDEPTH; i++)
                tdelay[i] = '0;
            col        = 0;
            spatial_on = 1'b1;
            row_w      = ROW_WIDTH_RESET;
            errors     = 0;
        endfunction

        function int iabs(int v);
            return (v < 0) ? -v : v;
        endfunction

        function int imax(int a, int b);
            return (a > b) ? a : b;
        endfunction

        function int imin(int a, int b);
            return (a < b) ? a : b;
        endfunction

        function int edge_score(int j);
            int s;
            s = 0;
            for (int k = -1; k <= 1; k++)
                s += iabs(int'(above_win[CEN + k + j]) - int'(below_win[CEN + k - j]));
            return s;
        endfunction

        function int diag_average(int j);
            return (int'(above_win[CEN + j]) + int'(below_win[CEN - j])) / 2;
        endfunction

        function pix_t predict_pixel(tfields_t t);
            int best, pred, s, c, e, d, td0, td1, td2, diff, b, f, hi, lo;
            best = edge_score(0);
            pred = diag_average(0);
            // a wider angle is only tried once the narrower one has won
            s = edge_score(-1);
            if (best > s)
            begin
                best = s;
                pred = diag_average(-1);
                s = edge_score(-2);
                if (best > s)
                begin
                    best = s;
                    pred = diag_average(-2);
                end
            end
            s = edge_score(1);
            if (best > s)
            begin
                best = s;
                pred = diag_average(1);
                s = edge_score(2);
                if (best > s)
                begin
                    best = s;
                    pred = diag_average(2);
                end
            end

            c    = int'(above_win[CEN]);
            e    = int'(below_win[CEN]);
            d    = (int'(t.prev_mid) + int'(t.next_mid)) / 2;
            td0  = iabs(int'(t.prev_mid) - int'(t.next_mid)) / 2;
            td1  = (iabs(int'(t.pf_above) - c) + iabs(int'(t.pf_below) - e)) / 2;
            td2  = (iabs(int'(t.nf_above) - c) + iabs(int'(t.nf_below) - e)) / 2;
            diff = imax(imax(td0, td1), td2);

            if (spatial_on)
            begin
                b    = (int'(t.prev_up2) + int'(t.next_up2)) >>> 1;
                f    = (int'(t.prev_down2) + int'(t.next_down2)) >>> 1;
                hi   = imax(imax(d - e, d - c), imin(b - c, f - e));
                lo   = imin(imin(d - e, d - c), imax(b - c, f - e));
                diff = imax(imax(diff, lo), -hi);
            end

            if (pred > d + diff)
                pred = d + diff;
            else if (pred < d - diff)
                pred = d - diff;
            return pred[7:0];
        endfunction

        function void note_register(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
            if (idx == CFG_SPATIAL_CHECK)
                spatial_on = data[0];
            else if (idx == CFG_ROW_WIDTH)
                row_w = data;
        endfunction

        function void note_column(column_t cb);
            tfields_t    aligned;
            int unsigned w;
            w = row_w;
            if (w < MIN_WIDTH)
                w = MIN_WIDTH;
            if (w > MAX_WIDTH)
                w = MAX_WIDTH;

            for (int i = 0; i < WIN - 1; i++)
            begin
                above_win[i] = above_win[i + 1];
                below_win[i] = below_win[i + 1];
            end
            above_win[WIN - 1] = cb.above;
            below_win[WIN - 1] = cb.below;

            // oldest delayed entry lines up with the window center
            aligned = tdelay[0];
            for (int i = 0; i < TDEPTH - 1; i++)
                tdelay[i] = tdelay[i + 1];
            tdelay[TDEPTH - 1] = cb.t;

            if (col >= FIRST_OUT)
                expected_pixels.push_back(predict_pixel(aligned));

            // a shrunk width ends the row at once
            if (col >= w - 1)
                col = 0;
            else
                col++;
        endfunction

        function void check_pixel(pix_t actual);
            pix_t exp_pix;
            if (expected_pixels.size() == 0)
            begin
                $error("pixel_out: expected none, actual %0d", actual);
                errors++;
            end
            else
            begin
                exp_pix = expected_pixels.pop_front();
                if (exp_pix !== actual)
                begin
                    $error("pixel_out: expected %0d, actual %0d", exp_pix, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ROW_W-1:0]     cfg_data;

    logic       in_valid;
    logic       in_ready;
    logic [7:0] above_pixel;
    logic [7:0] below_pixel;
    logic [7:0] temporal_prev_mid;
    logic [7:0] temporal_next_mid;
    logic [7:0] temporal_prev_up2;
    logic [7:0] temporal_prev_down2;
    logic [7:0] temporal_next_up2;
    logic [7:0] temporal_next_down2;
    logic [7:0] prev_frame_above;
    logic [7:0] prev_frame_below;
    logic [7:0] next_frame_above;
    logic [7:0] next_frame_below;

    logic       out_valid;
    logic       out_ready;
    logic [7:0] pixel_out;

    deinterlace_scoreboard sb;

    int stuck_cycles;
    int recv_stall_pct;
    int hold_req;
    int hold_seen;
    int hold_left;

    // scene used to shape correlated random columns
    int scene_lo;
    int scene_hi;
    int scene_mid;
    int tspread;
    int edge_shift;
    int gen_pos;

    int phase_width   [NUM_PHASES] = '{7, 0, 4096, 8191, -1, 4097, 13, -1};
    int phase_spatial [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 1, -1};
    int phase_mode    [NUM_PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                       IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
    int phase_items   [NUM_PHASES] = '{150, 100, 120, 100, 150, 80, 150, 200};

    yadif_line_deinterlace dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .above_pixel         (above_pixel),
        .below_pixel         (below_pixel),
        .temporal_prev_mid   (temporal_prev_mid),
        .temporal_next_mid   (temporal_next_mid),
        .temporal_prev_up2   (temporal_prev_up2),
        .temporal_prev_down2 (temporal_prev_down2),
        .temporal_next_up2   (temporal_next_up2),
        .temporal_next_down2 (temporal_next_down2),
        .prev_frame_above    (prev_frame_above),
        .prev_frame_below    (prev_frame_below),
        .next_frame_above    (next_frame_above),
        .next_frame_below    (next_frame_below),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .pixel_out           (pixel_out)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF;
            clk = ~clk;
        end
    end

    // samples every beat at the edge that takes it
    always @(posedge clk)
    begin
        column_t seen;
        bit      moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                sb.note_register(cfg_index, cfg_data);
                moved = 1'b1;
            end
            if (in_valid && in_ready)
            begin
                seen.above        = above_pixel;
                seen.below        = below_pixel;
                seen.t.prev_mid   = temporal_prev_mid;
                seen.t.next_mid   = temporal_next_mid;
                seen.t.prev_up2   = temporal_prev_up2;
                seen.t.prev_down2 = temporal_prev_down2;
                seen.t.next_up2   = temporal_next_up2;
                seen.t.next_down2 = temporal_next_down2;
                seen.t.pf_above   = prev_frame_above;
                seen.t.pf_below   = prev_frame_below;
                seen.t.nf_above   = next_frame_above;
                seen.t.nf_below   = next_frame_below;
                sb.note_column(seen);
                moved = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                sb.check_pixel(pixel_out);
                moved = 1'b1;
            end
        end
        stuck_cycles = moved ? 0 : stuck_cycles + 1;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
        end
    end

    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    function automatic pix_t jitter(int v, int amp);
        int r;
        r = v + int'($urandom_range(2 * amp)) - amp;
        if (r < 0)
            r = 0;
        if (r > 255)
            r = 255;
        return 8'(r);
    endfunction

    // called at an edge; leaves the beat accepted at the returning edge
    task automatic drive_column(column_t cb, int idle_pct);
        int gaps;
        gaps = 0;
        while (int'($urandom_range(99)) < idle_pct)
            gaps++;
        if (gaps > 0)
        begin
            in_valid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        in_valid            <= 1'b1;
        above_pixel         <= cb.above;
        below_pixel         <= cb.below;
        temporal_prev_mid   <= cb.t.prev_mid;
        temporal_next_mid   <= cb.t.next_mid;
        temporal_prev_up2   <= cb.t.prev_up2;
        temporal_prev_down2 <= cb.t.prev_down2;
        temporal_next_up2   <= cb.t.next_up2;
        temporal_next_down2 <= cb.t.next_down2;
        prev_frame_above    <= cb.t.pf_above;
        prev_frame_below    <= cb.t.pf_below;
        next_frame_above    <= cb.t.nf_above;
        next_frame_below    <= cb.t.nf_below;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // columns outside the row edges leave nothing to wait on, hence the tail
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int n_items, int idle_pct);
        column_t cb;
        for (int n = 0; n < n_items; n++)
        begin
            if ($urandom_range(15) == 0)
            begin
                scene_lo   = int'($urandom_range(255));
                scene_hi   = int'($urandom_range(255));
                scene_mid  = int'($urandom_range(255));
                tspread    = int'($urandom_range(40));
                edge_shift = int'($urandom_range(4)) - 2;
            end
            if ($urandom_range(3) == 0)
            begin
                cb.above = 8'($urandom);
                cb.below = 8'($urandom);
                cb.t     = tfields_t'({$urandom, $urandom, 16'($urandom)});
            end
            else
            begin
                // stripes offset between the lines so one diagonal matches
                cb.above        = jitter(((gen_pos & 7) < 4) ? scene_lo : scene_hi, 3);
                cb.below        = jitter((((gen_pos + 2 * edge_shift) & 7) < 4) ?
                                         scene_lo : scene_hi, 3);
                cb.t.prev_mid   = jitter(scene_mid, tspread);
                cb.t.next_mid   = jitter(scene_mid, tspread);
                cb.t.prev_up2   = jitter(scene_mid, tspread);
                cb.t.prev_down2 = jitter(scene_mid, tspread);
                cb.t.next_up2   = jitter(scene_mid, tspread);
                cb.t.next_down2 = jitter(scene_mid, tspread);
                cb.t.pf_above   = jitter(int'(cb.above), tspread);
                cb.t.pf_below   = jitter(int'(cb.below), tspread);
                cb.t.nf_above   = jitter(int'(cb.above), tspread);
                cb.t.nf_below   = jitter(int'(cb.below), tspread);
            end
            drive_column(cb, idle_pct);
            gen_pos++;
        end
    endtask

    initial
    begin
        column_t cb;
        int      spatial;
        int      width;
        int      send_pct;
        int      j;

        sb                  = new();
        stuck_cycles        = 0;
        recv_stall_pct      = 0;
        hold_req            = 0;
        hold_seen           = 0;
        hold_left           = 0;
        scene_lo            = 16;
        scene_hi            = 235;
        scene_mid           = 128;
        tspread             = 8;
        edge_shift          = 1;
        gen_pos             = 0;
        rst_n               = 1'b0;
        cfg_valid           = 1'b0;
        cfg_index           = CFG_SPATIAL_CHECK;
        cfg_data            = '0;
        in_valid            = 1'b0;
        above_pixel         = '0;
        below_pixel         = '0;
        temporal_prev_mid   = '0;
        temporal_next_mid   = '0;
        temporal_prev_up2   = '0;
        temporal_prev_down2 = '0;
        temporal_next_up2   = '0;
        temporal_next_down2 = '0;
        prev_frame_above    = '0;
        prev_frame_below    = '0;
        next_frame_above    = '0;
        next_frame_below    = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_SPATIAL_CHECK, 13'd1);
        write_reg(CFG_ROW_WIDTH, 13'd24);
        write_reg(CFG_SPARE_2, 13'd5);
        write_reg(CFG_SPARE_3, 13'h1FFF);

        // directed row: black, white, full-swing alternation, steep diagonals
        for (int i = 0; i < 24; i++)
        begin
            if (i < 8)
                cb = '0;
            else if (i < 12)
                cb = '1;
            else if (i < 16)
            begin
                cb.above = (i % 2 == 1) ? 8'd255 : 8'd0;
                cb.below = ~cb.above;
                cb.t     = {8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                            8'd0, 8'd0, 8'd255, 8'd255, 8'd0};
                if (i % 2 == 0)
                    cb.t = ~cb.t;
            end
            else
            begin
                j          = (i < 20) ? 2 : -2;
                cb.above   = 8'((i * 37) & 255);
                cb.below   = 8'(((i + 2 * j) * 37) & 255);
                cb.t       = {10{8'd128}};
                cb.t.prev_mid = 8'd100;
                cb.t.next_mid = 8'd160;
            end
            drive_column(cb, 0);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            spatial = (phase_spatial[p] < 0) ? int'($urandom_range(1)) : phase_spatial[p];
            width   = (phase_width[p] < 0) ? int'($urandom_range(40, 8)) : phase_width[p];
            write_reg(CFG_SPATIAL_CHECK, ROW_W'(spatial));
            write_reg(CFG_ROW_WIDTH, ROW_W'(width));
            case (phase_mode[p])
                IDLE_SEND:
                begin
                    send_pct       = 83;
                    recv_stall_pct = 0;
                end
                IDLE_RECV:
                begin
                    send_pct       = 0;
                    recv_stall_pct = 83;
                    hold_req++;
                end
                IDLE_BOTH:
                begin
                    send_pct       = 10;
                    recv_stall_pct = 10;
                end
                default:
                begin
                    send_pct       = 0;
                    recv_stall_pct = 0;
                end
            endcase
            run_phase(phase_items[p], send_pct);
        end

        wait_idle();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
